// ===== rtl/core/dsf_pkg.sv =====
`timescale 1ns / 1ps
package dsf_pkg;

   localparam int W     = 32;            // field width
   localparam int F     = 16;            // fraction bits
   localparam int CW    = W - 1;         // register width
   localparam int MAGW  = W + 1;         // magnitude of a difference
   localparam int SW    = 2 * MAGW;      // sum of squares
   localparam int LW    = SW / 2;        // length, also sqrt steps
   localparam int RW    = LW + 2;        // sqrt partial remainder
   localparam int UW    = F + 1;         // unit component magnitude, also divide steps
   localparam int NW    = MAGW + F;      // dividend
   localparam int PRW   = MAGW + UW;     // dv * u product
   localparam int DTW   = PRW + 2;       // signed dot sum
   localparam int DMW   = DTW - F;       // dot magnitude after scaling
   localparam int EMW   = LW;            // length error magnitude
   localparam int KW    = CW + DMW;      // k * magnitude product
   localparam int FMW   = KW + UW - 2 * F;
   localparam int FW    = FMW + 1;       // signed force before saturation
   localparam int TW    = FW + 1;        // signed total before saturation
   localparam int CSR_IW = 2;

   localparam logic [CSR_IW-1:0] CSR_STIFFNESS   = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_DAMPING     = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_REST_LENGTH = 2'd2;

   localparam logic [CW-1:0] STIFFNESS_RESET = CW'(1) << F;

   typedef struct packed {
      logic signed [W-1:0] pos_a_x;
      logic signed [W-1:0] pos_a_y;
      logic signed [W-1:0] pos_a_z;
      logic signed [W-1:0] pos_b_x;
      logic signed [W-1:0] pos_b_y;
      logic signed [W-1:0] pos_b_z;
      logic signed [W-1:0] vel_a_x;
      logic signed [W-1:0] vel_a_y;
      logic signed [W-1:0] vel_a_z;
      logic signed [W-1:0] vel_b_x;
      logic signed [W-1:0] vel_b_y;
      logic signed [W-1:0] vel_b_z;
   } req_type;

   typedef struct packed {
      logic signed [W-1:0] total_x;
      logic signed [W-1:0] total_y;
      logic signed [W-1:0] total_z;
      logic signed [W-1:0] spring_x;
      logic signed [W-1:0] spring_y;
      logic signed [W-1:0] spring_z;
      logic signed [W-1:0] damp_x;
      logic signed [W-1:0] damp_y;
      logic signed [W-1:0] damp_z;
      logic        [W-1:0] length;
   } rsp_type;

   // sign and magnitude of the separation and of the relative velocity
   typedef struct packed {
      logic [2:0][MAGW-1:0] dm;
      logic [2:0]           dn;
      logic [2:0][MAGW-1:0] dvm;
      logic [2:0]           dvn;
   } side_type;

   typedef struct packed {
      logic [SW-1:0] sum;
      side_type      side;
   } sq_in_type;

   typedef struct packed {
      logic [LW-1:0] len;
      side_type      side;
   } sq_out_type;

   typedef struct packed {
      logic [RW-1:0] rem;
      logic [LW-1:0] root;
      logic [SW-1:0] rad;
   } sq_st_type;

   typedef struct packed {
      logic [2:0][NW-1:0] rem;
      logic [2:0][UW-1:0] q;
   } div_st_type;

   typedef struct packed {
      logic [LW-1:0]        len;
      logic [2:0][UW-1:0]   um;
      logic [2:0]           dn;
      logic [2:0][MAGW-1:0] dvm;
      logic [2:0]           dvn;
   } div_out_type;

   typedef struct packed {
      logic [LW-1:0]      len;
      logic [2:0][FW-1:0] fs;
      logic [2:0][FW-1:0] fd;
   } frc_out_type;

   function automatic logic [W-1:0] sat_signed(input logic [TW-1:0] v);
      logic [W-1:0] r;
      if (v[TW-1:W-1] == '0 || v[TW-1:W-1] == '1) begin
         r = v[W-1:0];
      end else if (v[TW-1]) begin
         r = {1'b1, {(W-1){1'b0}}};
      end else begin
         r = {1'b0, {(W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/dsf_isqrt.sv =====
`timescale 1ns / 1ps
module dsf_isqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  dsf_pkg::sq_in_type in_data,
   output logic               out_vld,
   output dsf_pkg::sq_out_type out_data
);

   dsf_pkg::sq_st_type st_ff [dsf_pkg::LW];
   dsf_pkg::sq_st_type st_in [dsf_pkg::LW];
   dsf_pkg::side_type  side_ff [dsf_pkg::LW];
   logic [dsf_pkg::LW-1:0] vld_ff;

   // one root bit per stage: bring down two radicand bits, try root*4+1
   function automatic dsf_pkg::sq_st_type sq_step(input dsf_pkg::sq_st_type s);
      logic [dsf_pkg::RW-1:0] rsh;
      logic [dsf_pkg::RW-1:0] trial;
      dsf_pkg::sq_st_type r;
      rsh   = {s.rem[dsf_pkg::RW-3:0], s.rad[dsf_pkg::SW-1 -: 2]};
      trial = {s.root, 2'b01};
      r.rad = s.rad << 2;
      if (rsh >= trial) begin
         r.rem  = rsh - trial;
         r.root = {s.root[dsf_pkg::LW-2:0], 1'b1};
      end else begin
         r.rem  = rsh;
         r.root = {s.root[dsf_pkg::LW-2:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      dsf_pkg::sq_st_type s0;
      s0.rem  = '0;
      s0.root = '0;
      s0.rad  = in_data.sum;
      st_in[0] = sq_step(s0);
      for (int k = 1; k < dsf_pkg::LW; k++) begin
         st_in[k] = sq_step(st_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[dsf_pkg::LW-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff      <= st_in;
         side_ff[0] <= in_data.side;
         for (int k = 1; k < dsf_pkg::LW; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_vld       = vld_ff[dsf_pkg::LW-1];
   assign out_data.len  = st_ff[dsf_pkg::LW-1].root;
   assign out_data.side = side_ff[dsf_pkg::LW-1];

endmodule

// ===== rtl/core/dsf_udiv.sv =====
`timescale 1ns / 1ps
module dsf_udiv (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  dsf_pkg::sq_out_type in_data,
   output logic                out_vld,
   output dsf_pkg::div_out_type out_data
);

   dsf_pkg::div_st_type st_ff [dsf_pkg::UW];
   dsf_pkg::div_st_type st_in [dsf_pkg::UW];
   dsf_pkg::sq_out_type car_ff [dsf_pkg::UW];
   logic [dsf_pkg::UW-1:0] vld_ff;

   // one quotient bit per stage for all three lanes
   function automatic dsf_pkg::div_st_type dv_step(input dsf_pkg::div_st_type s,
                                                   input logic [dsf_pkg::LW-1:0] len,
                                                   input int sh);
      logic [dsf_pkg::NW-1:0] dsh;
      dsf_pkg::div_st_type r;
      dsh = dsf_pkg::NW'(len) << sh;
      for (int i = 0; i < 3; i++) begin
         if (s.rem[i] >= dsh) begin
            r.rem[i] = s.rem[i] - dsh;
            r.q[i]   = {s.q[i][dsf_pkg::UW-2:0], 1'b1};
         end else begin
            r.rem[i] = s.rem[i];
            r.q[i]   = {s.q[i][dsf_pkg::UW-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   always_comb begin
      dsf_pkg::div_st_type s0;
      for (int i = 0; i < 3; i++) begin
         s0.rem[i] = dsf_pkg::NW'(in_data.side.dm[i]) << dsf_pkg::F;
         s0.q[i]   = '0;
      end
      st_in[0] = dv_step(s0, in_data.len, dsf_pkg::F);
      for (int k = 1; k < dsf_pkg::UW; k++) begin
         st_in[k] = dv_step(st_ff[k-1], car_ff[k-1].len, dsf_pkg::F - k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[dsf_pkg::UW-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff     <= st_in;
         car_ff[0] <= in_data;
         for (int k = 1; k < dsf_pkg::UW; k++) begin
            car_ff[k] <= car_ff[k-1];
         end
      end
   end

   assign out_vld      = vld_ff[dsf_pkg::UW-1];
   assign out_data.len = car_ff[dsf_pkg::UW-1].len;
   assign out_data.um  = st_ff[dsf_pkg::UW-1].q;
   assign out_data.dn  = car_ff[dsf_pkg::UW-1].side.dn;
   assign out_data.dvm = car_ff[dsf_pkg::UW-1].side.dvm;
   assign out_data.dvn = car_ff[dsf_pkg::UW-1].side.dvn;

endmodule

// ===== rtl/core/dsf_force.sv =====
`timescale 1ns / 1ps
module dsf_force (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic [dsf_pkg::CW-1:0] stiffness,
   input  logic [dsf_pkg::CW-1:0] damping,
   input  logic [dsf_pkg::CW-1:0] rest_length,
   input  logic                 in_vld,
   input  dsf_pkg::div_out_type in_data,
   output logic                 out_vld,
   output dsf_pkg::frc_out_type out_data
);

   localparam int NSTG = 6;
   localparam int LOW  = dsf_pkg::W + dsf_pkg::UW;
   localparam int HIW  = dsf_pkg::KW - dsf_pkg::W + dsf_pkg::UW;
   localparam int FUW  = dsf_pkg::KW + dsf_pkg::UW;

   logic [NSTG-1:0] vld_ff;

   // common carry: length, unit magnitudes, lane signs and the length error
   logic [dsf_pkg::LW-1:0]      len_ff [NSTG];
   logic [2:0][dsf_pkg::UW-1:0] um_ff  [NSTG-1];
   logic [2:0]                  dn_ff  [NSTG-1];
   logic [dsf_pkg::EMW-1:0]     em_ff  [NSTG-3];
   logic                        eneg_ff [NSTG-1];

   // stage 1: dv * u per lane, length error
   logic [2:0][dsf_pkg::PRW-1:0] pr_ff, pr_in;
   logic [2:0]                   ps_ff, ps_in;
   logic [dsf_pkg::EMW-1:0]      em_in;
   logic                         eneg_in;
   // stage 2: dot sum
   logic [dsf_pkg::DTW-1:0]      dot_ff, dot_in;
   // stage 3: dot magnitude
   logic [dsf_pkg::DMW-1:0]      dmag_ff, dmag_in;
   logic                         dneg_ff [3];
   // stage 4: k * magnitude
   logic [dsf_pkg::KW-1:0]       kps_ff, kps_in, kpd_ff, kpd_in;
   // stage 5: partial products with u
   logic [2:0][LOW-1:0]          slo_ff, slo_in, dlo_ff, dlo_in;
   logic [2:0][HIW-1:0]          shi_ff, shi_in, dhi_ff, dhi_in;
   // stage 6: signed forces
   logic [2:0][dsf_pkg::FW-1:0]  fs_ff, fs_in, fd_ff, fd_in;

   always_comb begin
      logic [dsf_pkg::EMW-1:0] rest;
      logic [dsf_pkg::DTW-1:0] acc;
      logic [dsf_pkg::DTW-1:0] term;
      logic [dsf_pkg::DTW-1:0] dabs;
      logic [FUW-1:0]          sfull;
      logic [FUW-1:0]          dfull;
      logic [dsf_pkg::FW-1:0]  smag;
      logic [dsf_pkg::FW-1:0]  dmg;

      for (int i = 0; i < 3; i++) begin
         pr_in[i] = dsf_pkg::PRW'(in_data.dvm[i]) * dsf_pkg::PRW'(in_data.um[i]);
         ps_in[i] = in_data.dvn[i] ^ in_data.dn[i];
      end
      rest    = dsf_pkg::EMW'(rest_length);
      eneg_in = in_data.len < rest;
      em_in   = eneg_in ? rest - in_data.len : in_data.len - rest;

      acc = '0;
      for (int i = 0; i < 3; i++) begin
         term = dsf_pkg::DTW'(pr_ff[i]);
         acc  = ps_ff[i] ? acc - term : acc + term;
      end
      dot_in = acc;

      dabs    = dot_ff[dsf_pkg::DTW-1] ? -dot_ff : dot_ff;
      dmag_in = dabs[dsf_pkg::F +: dsf_pkg::DMW];

      kps_in = dsf_pkg::KW'(stiffness) * dsf_pkg::KW'(em_ff[NSTG-4]);
      kpd_in = dsf_pkg::KW'(damping) * dsf_pkg::KW'(dmag_ff);

      for (int i = 0; i < 3; i++) begin
         slo_in[i] = LOW'(kps_ff[dsf_pkg::W-1:0]) * LOW'(um_ff[NSTG-3][i]);
         shi_in[i] = HIW'(kps_ff[dsf_pkg::KW-1:dsf_pkg::W]) * HIW'(um_ff[NSTG-3][i]);
         dlo_in[i] = LOW'(kpd_ff[dsf_pkg::W-1:0]) * LOW'(um_ff[NSTG-3][i]);
         dhi_in[i] = HIW'(kpd_ff[dsf_pkg::KW-1:dsf_pkg::W]) * HIW'(um_ff[NSTG-3][i]);
      end

      for (int i = 0; i < 3; i++) begin
         sfull = (FUW'(shi_ff[i]) << dsf_pkg::W) + FUW'(slo_ff[i]);
         dfull = (FUW'(dhi_ff[i]) << dsf_pkg::W) + FUW'(dlo_ff[i]);
         smag  = dsf_pkg::FW'(sfull[2*dsf_pkg::F +: dsf_pkg::FMW]);
         dmg   = dsf_pkg::FW'(dfull[2*dsf_pkg::F +: dsf_pkg::FMW]);
         fs_in[i] = (eneg_ff[NSTG-2] ^ dn_ff[NSTG-2][i]) ? -smag : smag;
         fd_in[i] = (dneg_ff[2] ^ dn_ff[NSTG-2][i]) ? -dmg : dmg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         len_ff[0]  <= in_data.len;
         um_ff[0]   <= in_data.um;
         dn_ff[0]   <= in_data.dn;
         em_ff[0]   <= em_in;
         eneg_ff[0] <= eneg_in;
         for (int k = 1; k < NSTG; k++) begin
            len_ff[k] <= len_ff[k-1];
         end
         for (int k = 1; k < NSTG-1; k++) begin
            um_ff[k]   <= um_ff[k-1];
            dn_ff[k]   <= dn_ff[k-1];
            eneg_ff[k] <= eneg_ff[k-1];
         end
         for (int k = 1; k < NSTG-3; k++) begin
            em_ff[k] <= em_ff[k-1];
         end
         pr_ff      <= pr_in;
         ps_ff      <= ps_in;
         dot_ff     <= dot_in;
         dmag_ff    <= dmag_in;
         dneg_ff[0] <= dot_ff[dsf_pkg::DTW-1];
         dneg_ff[1] <= dneg_ff[0];
         dneg_ff[2] <= dneg_ff[1];
         kps_ff     <= kps_in;
         kpd_ff     <= kpd_in;
         slo_ff     <= slo_in;
         shi_ff     <= shi_in;
         dlo_ff     <= dlo_in;
         dhi_ff     <= dhi_in;
         fs_ff      <= fs_in;
         fd_ff      <= fd_in;
      end
   end

   assign out_vld      = vld_ff[NSTG-1];
   assign out_data.len = len_ff[NSTG-1];
   assign out_data.fs  = fs_ff;
   assign out_data.fd  = fd_ff;

endmodule

// ===== rtl/core/damped_spring_force.sv =====
`timescale 1ns / 1ps
// Damped spring force, one spring per word, signed Q16.16 throughout.
// req channel: positions and velocities of both end points (valid/ready).
// rsp channel: total, spring and damping force on end A plus the length.
// csr port: write enable, index (0 stiffness, 1 damping, 2 rest length),
// 31-bit data; other indexes are dropped. Write only while the block is idle.
// An accepted req word reaches rsp_valid through the 33 stages of the
// bit-per-stage square root and the 17 stages of the bit-per-stage
// divider, plus 4 front and 7 back stages.
// Throughput: one word per cycle while rsp_ready is high.
// The whole pipeline advances together; when rsp holds a word that is not
// taken, req_ready drops and every stage holds, so nothing is lost or
// repeated. Bubbles travel as empty stages.
// Reset clears all valid bits and loads stiffness 1.0, damping 0 and rest
// length 0. A zero length gives zero forces.
module damped_spring_force (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  dsf_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output dsf_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [dsf_pkg::CSR_IW-1:0] csr_index,
   input  logic [dsf_pkg::CW-1:0]    csr_wdata
);

   logic en;

   logic [dsf_pkg::CW-1:0] stiff_ff, damp_ff, rest_ff;

   logic [3:0] fv_ff;
   // stage 1: differences
   logic [2:0][dsf_pkg::MAGW-1:0] d_ff, d_in, dv_ff, dv_in;
   // stage 2: sign and magnitude
   dsf_pkg::side_type side2_ff, side2_in, side3_ff;
   // stage 3: squares
   logic [2:0][dsf_pkg::SW-1:0] sq_ff, sq_in;
   // stage 4: sum of squares
   dsf_pkg::sq_in_type sqi_ff, sqi_in;

   logic                  sq_vld, dv_vld, fr_vld;
   dsf_pkg::sq_out_type   sq_out;
   dsf_pkg::div_out_type  dv_out;
   dsf_pkg::frc_out_type  fr_out;

   logic             rsp_valid_ff;
   dsf_pkg::rsp_type rsp_ff, rsp_in;

   assign en        = ~rsp_valid_ff | rsp_ready;
   assign req_ready = en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff <= dsf_pkg::STIFFNESS_RESET;
         damp_ff  <= '0;
         rest_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            dsf_pkg::CSR_STIFFNESS:   stiff_ff <= csr_wdata;
            dsf_pkg::CSR_DAMPING:     damp_ff  <= csr_wdata;
            dsf_pkg::CSR_REST_LENGTH: rest_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [2:0][dsf_pkg::W-1:0] pa, pb, va, vb;
      pa = {req_data.pos_a_z, req_data.pos_a_y, req_data.pos_a_x};
      pb = {req_data.pos_b_z, req_data.pos_b_y, req_data.pos_b_x};
      va = {req_data.vel_a_z, req_data.vel_a_y, req_data.vel_a_x};
      vb = {req_data.vel_b_z, req_data.vel_b_y, req_data.vel_b_x};
      for (int i = 0; i < 3; i++) begin
         d_in[i]  = {pb[i][dsf_pkg::W-1], pb[i]} - {pa[i][dsf_pkg::W-1], pa[i]};
         dv_in[i] = {vb[i][dsf_pkg::W-1], vb[i]} - {va[i][dsf_pkg::W-1], va[i]};
      end

      for (int i = 0; i < 3; i++) begin
         side2_in.dn[i]  = d_ff[i][dsf_pkg::MAGW-1];
         side2_in.dm[i]  = side2_in.dn[i] ? -d_ff[i] : d_ff[i];
         side2_in.dvn[i] = dv_ff[i][dsf_pkg::MAGW-1];
         side2_in.dvm[i] = side2_in.dvn[i] ? -dv_ff[i] : dv_ff[i];
      end

      for (int i = 0; i < 3; i++) begin
         sq_in[i] = dsf_pkg::SW'(side2_ff.dm[i]) * dsf_pkg::SW'(side2_ff.dm[i]);
      end

      sqi_in.sum  = sq_ff[0] + sq_ff[1] + sq_ff[2];
      sqi_in.side = side3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (en) begin
         fv_ff <= {fv_ff[2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff     <= d_in;
         dv_ff    <= dv_in;
         side2_ff <= side2_in;
         sq_ff    <= sq_in;
         side3_ff <= side2_ff;
         sqi_ff   <= sqi_in;
      end
   end

   dsf_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (fv_ff[3]),
      .in_data  (sqi_ff),
      .out_vld  (sq_vld),
      .out_data (sq_out)
   );

   dsf_udiv u_udiv (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (sq_vld),
      .in_data  (sq_out),
      .out_vld  (dv_vld),
      .out_data (dv_out)
   );

   dsf_force u_force (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .stiffness   (stiff_ff),
      .damping     (damp_ff),
      .rest_length (rest_ff),
      .in_vld      (dv_vld),
      .in_data     (dv_out),
      .out_vld     (fr_vld),
      .out_data    (fr_out)
   );

   // sum, saturate, zero the forces for a zero length
   always_comb begin
      logic [2:0][dsf_pkg::TW-1:0] tot, fse, fde;
      logic [2:0][dsf_pkg::W-1:0]  ts, ss, ds;
      logic zero;
      zero = fr_out.len == '0;
      for (int i = 0; i < 3; i++) begin
         fse[i] = {fr_out.fs[i][dsf_pkg::FW-1], fr_out.fs[i]};
         fde[i] = {fr_out.fd[i][dsf_pkg::FW-1], fr_out.fd[i]};
         tot[i] = fse[i] + fde[i];
         ts[i]  = zero ? '0 : dsf_pkg::sat_signed(tot[i]);
         ss[i]  = zero ? '0 : dsf_pkg::sat_signed(fse[i]);
         ds[i]  = zero ? '0 : dsf_pkg::sat_signed(fde[i]);
      end
      rsp_in.total_x  = ts[0];
      rsp_in.total_y  = ts[1];
      rsp_in.total_z  = ts[2];
      rsp_in.spring_x = ss[0];
      rsp_in.spring_y = ss[1];
      rsp_in.spring_z = ss[2];
      rsp_in.damp_x   = ds[0];
      rsp_in.damp_y   = ds[1];
      rsp_in.damp_z   = ds[2];
      rsp_in.length   = (fr_out.len[dsf_pkg::LW-1:dsf_pkg::W] != '0) ? '1
                                                                    : fr_out.len[dsf_pkg::W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= fr_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
